// File: hdl/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

  localparam int CHAN_W  = 8;
  localparam int SUM_W   = CHAN_W + 1;
  localparam int NUM_W   = CHAN_W;
  localparam int DEN_W   = CHAN_W + 1;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 16;
  localparam int LIGHT_W = 16;

  // divider: one initial compare plus DIV_STEPS restoring steps per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 4;
  localparam int QUO_W      = 1 + DIV_STAGES * DIV_STEPS;

  // hue in sixth-sector units, wrapped and unwrapped
  localparam int HSIX_W = 20;
  localparam int HWRAP_W = 19;
  localparam int HPROD_W = 23;

  localparam logic [SUM_W-1:0]   HALF_SUM    = SUM_W'(256);
  localparam logic [SUM_W:0]     TWO_SUM     = (SUM_W + 1)'(512);
  localparam logic [HSIX_W-1:0]  SECTOR_GRN  = HSIX_W'(20'h20000);
  localparam logic [HSIX_W-1:0]  SECTOR_BLU  = HSIX_W'(20'h40000);
  localparam logic [HSIX_W-1:0]  FULL_CIRCLE = HSIX_W'(20'h60000);
  localparam logic [HPROD_W-1:0] HUE_MUL     = HPROD_W'(15);
  localparam int                 HUE_SHIFT   = 8;

  // pipeline stage indexes
  localparam int ST_FRONT = 0;
  localparam int ST_DIV0  = 1;
  localparam int ST_BACK  = ST_DIV0 + DIV_STAGES;
  localparam int ST_NUM   = ST_BACK + 2;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    sector_t              sector;
    logic                 neg;
    logic                 gray;
    logic [LIGHT_W-1:0]   light;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [NUM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    side_t            side;
  } front_t;

endpackage

// File: hdl/rth_pix_if.sv
`timescale 1ns / 1ps

interface rth_pix_if;
  logic           valid;
  logic           ready;
  rth_pkg::chan_t red;
  rth_pkg::chan_t green;
  rth_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/rth_hsl_if.sv
`timescale 1ns / 1ps

interface rth_hsl_if;
  logic                          valid;
  logic                          ready;
  logic [rth_pkg::HUE_W-1:0]     hue;
  logic [rth_pkg::SAT_W-1:0]     saturation;
  logic [rth_pkg::LIGHT_W-1:0]   lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// File: hdl/rth_front.sv
`timescale 1ns / 1ps

module rth_front (
  input  logic            clk,
  input  logic            en,
  input  rth_pkg::chan_t  red,
  input  rth_pkg::chan_t  green,
  input  rth_pkg::chan_t  blue,
  output rth_pkg::front_t fr_r
);
  import rth_pkg::*;

  chan_t              lo, hi, chroma, pa, pb;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W:0]     inv;
  sector_t            sector;
  front_t             fr_nxt;

  always_comb begin
    lo = red;
    hi = red;
    if (green < lo) lo = green;
    if (blue < lo)  lo = blue;
    if (green > hi) hi = green;
    if (blue > hi)  hi = blue;

    chroma = hi - lo;
    sum    = {1'b0, lo} + {1'b0, hi};
    inv    = TWO_SUM - {1'b0, sum};

    // max channel, red wins ties, then green
    if (red == hi) begin
      sector = SEC_RED;
      pa = green;
      pb = blue;
    end else if (green == hi) begin
      sector = SEC_GREEN;
      pa = blue;
      pb = red;
    end else begin
      sector = SEC_BLUE;
      pa = red;
      pb = green;
    end

    fr_nxt.sat_num     = chroma;
    fr_nxt.sat_den     = (sum < HALF_SUM) ? sum : inv[DEN_W-1:0];
    fr_nxt.hue_num     = (pa < pb) ? (pb - pa) : (pa - pb);
    fr_nxt.hue_den     = {1'b0, chroma};
    fr_nxt.side.sector = sector;
    fr_nxt.side.neg    = (pa < pb);
    fr_nxt.side.gray   = (lo == hi);
    fr_nxt.side.light  = LIGHT_W'({sum, 7'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
    end
  end

endmodule

// File: hdl/rth_div.sv
`timescale 1ns / 1ps

module rth_div (
  input  logic                                clk,
  input  logic [rth_pkg::DIV_STAGES-1:0]      en,
  input  logic [rth_pkg::NUM_W-1:0]           num,
  input  logic [rth_pkg::DEN_W-1:0]           den,
  output logic [rth_pkg::QUO_W-1:0]           quo
);
  import rth_pkg::*;

  // quotient of num * 2^(QUO_W-1) / den, num <= den
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  div_t             st_r   [DIV_STAGES];
  div_t             st_nxt [DIV_STAGES];
  logic [DEN_W-1:0] den_r  [DIV_STAGES-1];
  logic [DEN_W-1:0] x0;
  logic             b0;
  div_t             acc;

  function automatic div_t div_step(div_t a, logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    logic           bit_q;
    div_t           r;
    t      = {a.rem, 1'b0};
    bit_q  = (t >= {1'b0, d});
    r.quo  = {a.quo[QUO_W-2:0], bit_q};
    r.rem  = bit_q ? DEN_W'(t - {1'b0, d}) : t[DEN_W-1:0];
    return r;
  endfunction

  always_comb begin
    // leading quotient bit, set only when num equals den
    x0      = {1'b0, num};
    b0      = (x0 >= den);
    acc.rem = b0 ? (x0 - den) : x0;
    acc.quo = QUO_W'(b0);
    for (int j = 0; j < DIV_STEPS; j++) begin
      acc = div_step(acc, den);
    end
    st_nxt[0] = acc;
    for (int k = 1; k < DIV_STAGES; k++) begin
      acc = st_r[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        acc = div_step(acc, den_r[k-1]);
      end
      st_nxt[k] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st_r[0]  <= st_nxt[0];
      den_r[0] <= den;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
        if (k < DIV_STAGES - 1) begin
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].quo;

endmodule

// File: hdl/rth_back.sv
`timescale 1ns / 1ps

module rth_back (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic [rth_pkg::QUO_W-1:0]     hue_quo,
  input  logic [rth_pkg::QUO_W-1:0]     sat_quo,
  input  rth_pkg::side_t                side,
  output logic [rth_pkg::HUE_W-1:0]     hue_r,
  output logic [rth_pkg::SAT_W-1:0]     sat_r,
  output logic [rth_pkg::LIGHT_W-1:0]   light_r
);
  import rth_pkg::*;

  logic [HSIX_W-1:0]  offset;
  logic [HSIX_W-1:0]  hsix;
  logic [HSIX_W-1:0]  hwrap;
  logic [HWRAP_W-1:0] hw_nxt, hw_r;
  logic [SAT_W-1:0]   sm_nxt, sm_r;
  logic [LIGHT_W-1:0] lm_r;
  logic [HPROD_W-1:0] prod;

  always_comb begin
    unique case (side.sector)
      SEC_GREEN: offset = SECTOR_GRN;
      SEC_BLUE:  offset = SECTOR_BLU;
      default:   offset = '0;
    endcase
    hsix   = side.neg ? (offset - HSIX_W'(hue_quo)) : (offset + HSIX_W'(hue_quo));
    hwrap  = hsix[HSIX_W-1] ? (hsix + FULL_CIRCLE) : hsix;
    hw_nxt = side.gray ? '0 : hwrap[HWRAP_W-1:0];
    if (side.gray) begin
      sm_nxt = '0;
    end else if (sat_quo[QUO_W-1]) begin
      sm_nxt = '1;
    end else begin
      sm_nxt = sat_quo[SAT_W-1:0];
    end
  end

  assign prod = HPROD_W'(hw_r) * HUE_MUL;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hw_r <= hw_nxt;
      sm_r <= sm_nxt;
      lm_r <= side.light;
    end
    if (en[1]) begin
      hue_r   <= prod[HUE_SHIFT +: HUE_W];
      sat_r   <= sm_r;
      light_r <= lm_r;
    end
  end

endmodule

// File: hdl/rgb_to_hsl_fixed.sv
`timescale 1ns / 1ps

// channel   dir   handshake              beat
// in_pix    in    valid / ready          red, green, blue (8 bits each)
// out_hsl   out   valid / ready          hue (15), saturation (16), lightness (16)
//
// one pixel per clock sustained while out_hsl is ready, in order from input beat to output beat
// the two 17-bit restoring dividers are built as 4 stages of 4 steps
// synchronous active-low reset clears the stage valid bits only
// each stage moves when it is empty or the next one moves, so bubbles are
// squeezed out and a stalled output holds every stage without loss

module rgb_to_hsl_fixed (
  input  logic clk,
  input  logic rst_n,
  rth_pix_if.sink   in_pix,
  rth_hsl_if.source out_hsl
);
  import rth_pkg::*;

  logic [ST_NUM-1:0] vld_r;    // one valid bit per pipeline stage
  logic [ST_NUM-1:0] en;       // stage load enables
  front_t            fr_r;     // divider operands and side info from the min/max sort
  side_t             side_r [DIV_STAGES];
  logic [QUO_W-1:0]  hue_quo;
  logic [QUO_W-1:0]  sat_quo;

  // ready ripples back from the output: a stage loads if empty or draining
  always_comb begin
    en[ST_NUM-1] = !vld_r[ST_NUM-1] || out_hsl.ready;
    for (int i = ST_NUM - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_pix.ready = en[ST_FRONT];
  assign out_hsl.valid = vld_r[ST_NUM-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_pix.valid;
      end
      for (int i = 1; i < ST_NUM; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // stage 0: channel sort, sector pick, divider operands
  rth_front u_front (
    .clk   (clk),
    .en    (en[ST_FRONT]),
    .red   (in_pix.red),
    .green (in_pix.green),
    .blue  (in_pix.blue),
    .fr_r  (fr_r)
  );

  // stages 1..4: hue term |diff| * 65536 / chroma
  rth_div u_div_hue (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_STAGES]),
    .num (fr_r.hue_num),
    .den (fr_r.hue_den),
    .quo (hue_quo)
  );

  // stages 1..4: saturation chroma * 65536 / (sum or 512 - sum)
  rth_div u_div_sat (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_STAGES]),
    .num (fr_r.sat_num),
    .den (fr_r.sat_den),
    .quo (sat_quo)
  );

  // sector, sign, gray flag and lightness ride alongside the dividers
  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) begin
      side_r[0] <= fr_r.side;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[ST_DIV0 + k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage 5: sign, sector offset, wrap, saturate; stage 6: scale to 1/64 degree
  rth_back u_back (
    .clk     (clk),
    .en      (en[ST_BACK +: 2]),
    .hue_quo (hue_quo),
    .sat_quo (sat_quo),
    .side    (side_r[DIV_STAGES-1]),
    .hue_r   (out_hsl.hue),
    .sat_r   (out_hsl.saturation),
    .light_r (out_hsl.lightness)
  );

endmodule

// File: tb/sv/tb_rgb_to_hsl_fixed.sv
`timescale 1ns / 1ps

module tb_rgb_to_hsl_fixed;
  import rth_pkg::*;

  // one pixel beat as queued for the driver
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  // one hsl beat as predicted and as seen on the output
  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIGHT_W-1:0] lightness;
  } hsl_t;

  localparam int RANDOM_PIXELS = 450;
  localparam int LONG_HOLD     = 100;   // receiver hold-off, well past pipeline depth
  localparam int TAIL_CYCLES   = 20;    // margin after the drain before finishing
  localparam int STALL_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int REPORT_MAX    = 10;

  logic clk;
  logic rst_n;

  rth_pix_if pix ();
  rth_hsl_if hsl ();

  rgb_to_hsl_fixed dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_hsl (hsl)
  );

  pix_t pending_pix[$];   // pixels waiting to be driven
  hsl_t hsl_expected[$];  // predictions for accepted pixels, oldest first

  int   mismatches;
  int   gap_left;
  int   burst_left;
  int   hold_left;        // receiver long hold-off countdown
  logic hold_done;
  logic long_hold_go;
  logic [8:0] rx_cycle;   // drives the receiver's stall pattern
  int   quiet_cycles;

  // fixed-point rgb to hsl, computed in wide signed arithmetic
  function automatic hsl_t hsl_of(chan_t r, chan_t g, chan_t b);
    int     lo;
    int     hi;
    int     span;
    int     chroma;
    longint den;
    longint quo;
    longint six;
    hsl_t   res;
    res = '0;
    lo = int'(r);
    hi = int'(r);
    if (int'(g) < lo) lo = int'(g);
    if (int'(b) < lo) lo = int'(b);
    if (int'(g) > hi) hi = int'(g);
    if (int'(b) > hi) hi = int'(b);
    // gray pixel: no hue, no saturation, lightness is just the level
    if (lo == hi) begin
      res.lightness = LIGHT_W'(lo * 256);
      return res;
    end
    span   = lo + hi;
    chroma = hi - lo;
    res.lightness = LIGHT_W'(span * 128);
    // below half lightness divide by the sum, else by its complement to 512
    if (span * 128 < 'h8000) den = longint'(span) * 256;
    else den = 'h20000 - longint'(span) * 256;
    quo = (longint'(chroma) <<< 24) / den;
    // a quotient of exactly one clips to the top code
    res.saturation = (quo > 65535) ? 16'hFFFF : SAT_W'(quo);
    // max channel ties go red first, then green; division truncates toward zero
    if (int'(r) == hi) six = (longint'(int'(g) - int'(b)) * 65536) / chroma;
    else if (int'(g) == hi) six = (longint'(int'(b) - int'(r)) * 65536) / chroma + 64'sh20000;
    else six = (longint'(int'(r) - int'(g)) * 65536) / chroma + 64'sh40000;
    // negative hue wraps around the circle
    if (six < 0) six = six + 64'sh60000;
    // sixth-sector units to 1/64 degree
    res.hue = HUE_W'((six * 15) >> 8);
    return res;
  endfunction

  // random pixel, biased toward ties, grays, near-grays and rail values
  function automatic pix_t rand_pix();
    pix_t p;
    int   kind;
    p.red   = chan_t'($urandom);
    p.green = chan_t'($urandom);
    p.blue  = chan_t'($urandom);
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      // gray
      p.green = p.red;
      p.blue  = p.red;
    end else if (kind < 6) begin
      // two channels equal, at the max or the min
      case ($urandom_range(0, 2))
        0: p.green = p.red;
        1: p.blue  = p.red;
        default: p.blue = p.green;
      endcase
    end else if (kind < 9) begin
      // tiny chroma, largest quotients per unit of difference
      p.green = p.red ^ chan_t'($urandom_range(0, 3));
      p.blue  = p.red ^ chan_t'($urandom_range(0, 3));
    end else if (kind < 11) begin
      // channels on or next to the rails
      p.red   = chan_t'($urandom_range(0, 1) * 255) ^ chan_t'($urandom_range(0, 1));
      p.green = chan_t'($urandom_range(0, 1) * 255) ^ chan_t'($urandom_range(0, 1));
      p.blue  = chan_t'($urandom_range(0, 1) * 255) ^ chan_t'($urandom_range(0, 1));
    end
    return p;
  endfunction

  task automatic push_pix(int r, int g, int b);
    pix_t p;
    p.red   = chan_t'(r);
    p.green = chan_t'(g);
    p.blue  = chan_t'(b);
    pending_pix.push_back(p);
  endtask

  // idle until every queued pixel went in and every result came out;
  // checked on the falling edge so all updates of the rising edge are in
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pix.size() != 0 || pix.valid || hsl_expected.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver: bursts of random length separated by random gaps; gaps are
  // skipped while the receiver is in its long hold so the input backs up
  always @(posedge clk) begin : driver
    pix_t nxt;
    if (!rst_n) begin
      pix.valid  <= 1'b0;
      gap_left   = 0;
      burst_left = $urandom_range(1, 16);
    end else begin
      // accepted beat: predict its result now
      if (pix.valid && pix.ready)
        hsl_expected.push_back(hsl_of(pix.red, pix.green, pix.blue));
      // a beat still on offer must stay put until taken
      if (!pix.valid || pix.ready) begin
        if (pending_pix.size() != 0 && (gap_left == 0 || hold_left > 0)) begin
          nxt = pending_pix.pop_front();
          pix.valid <= 1'b1;
          pix.red   <= nxt.red;
          pix.green <= nxt.green;
          pix.blue  <= nxt.blue;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // receiver: stall pattern steps through four modes on rx_cycle's top bits, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hsl.ready <= 1'b0;
      rx_cycle  <= '0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (long_hold_go && !hold_done) begin
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
        hsl.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        hsl.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'b00: hsl.ready <= 1'b1;                               // never stalls
          2'b01: hsl.ready <= 1'($urandom_range(0, 1));           // coin flip
          2'b10: hsl.ready <= (rx_cycle[1:0] != 2'b00);           // periodic
          default: hsl.ready <= ($urandom_range(0, 7) != 0);      // rare stalls
        endcase
      end
    end
  end

  // monitor: every output beat against the oldest prediction
  always @(posedge clk) begin : monitor
    hsl_t want;
    if (rst_n && hsl.valid && hsl.ready) begin
      if (hsl_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: output beat with nothing expected: hue %0d sat %0d light %0d",
                   $realtime, hsl.hue, hsl.saturation, hsl.lightness);
      end else begin
        want = hsl_expected.pop_front();
        if (hsl.hue !== want.hue || hsl.saturation !== want.saturation ||
            hsl.lightness !== want.lightness) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch: hue %0d/%0d sat %0d/%0d light %0d/%0d (exp/act)",
                     $realtime, want.hue, hsl.hue, want.saturation, hsl.saturation,
                     want.lightness, hsl.lightness);
        end
      end
    end
  end

  // watchdog: too long without a beat on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (pix.valid && pix.ready) || (hsl.valid && hsl.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pix.valid    = 1'b0;
    pix.red      = '0;
    pix.green    = '0;
    pix.blue     = '0;
    hsl.ready    = 1'b0;
    rst_n        = 1'b0;
    long_hold_go = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: grays and rails
    push_pix(0, 0, 0);
    push_pix(255, 255, 255);
    push_pix(128, 128, 128);
    // primaries, one per sector
    push_pix(255, 0, 0);
    push_pix(0, 255, 0);
    push_pix(0, 0, 255);
    // max ties: red beats green and blue, green beats blue
    push_pix(255, 255, 0);
    push_pix(255, 0, 255);
    push_pix(0, 255, 255);
    // red max with blue above green wraps negative hue
    push_pix(255, 0, 1);
    push_pix(200, 10, 100);
    // zero min below half lightness gives a saturation of one, clipped
    push_pix(127, 0, 0);
    push_pix(1, 0, 0);
    push_pix(128, 0, 0);
    // lightness just below and exactly at one half
    push_pix(199, 56, 100);
    push_pix(200, 56, 100);
    // near-grays at both ends, then a full red with a trace of green
    push_pix(255, 254, 254);
    push_pix(254, 255, 255);
    push_pix(0, 1, 2);
    push_pix(255, 1, 0);
    // interior of the green and blue sectors, then an orange in the red sector
    push_pix(10, 200, 30);
    push_pix(30, 40, 250);
    push_pix(255, 128, 0);
    // sender pause: everything must come back before going on
    wait_drained();

    for (int i = 0; i < RANDOM_PIXELS; i++)
      pending_pix.push_back(rand_pix());
    // long receiver hold-off in the middle of the random traffic
    repeat (150) @(posedge clk);
    long_hold_go <= 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rth_pkg.sv
hdl/rth_pix_if.sv
hdl/rth_hsl_if.sv
hdl/rth_front.sv
hdl/rth_div.sv
hdl/rth_back.sv
hdl/rgb_to_hsl_fixed.sv
tb/sv/tb_rgb_to_hsl_fixed.sv
